// File: rtl/bcq_pkg.sv
package bcq_pkg;

   // Field widths
   localparam int PINS_W   = 3;
   localparam int TIME_W   = 32;
   localparam int CFG_W    = 16;
   localparam int CSR_IDX_W = 2;

   // Pin bit positions in a sample
   localparam int PIN_ENC_A  = 0;
   localparam int PIN_ENC_B  = 1;
   localparam int PIN_BUTTON = 2;

   // Reset values
   localparam logic [PINS_W-1:0] PINS_IDLE        = 3'b111;
   localparam logic [CFG_W-1:0]  DEBOUNCE_RST     = 16'd10;
   localparam logic [CFG_W-1:0]  DOUBLE_CLICK_RST = 16'd500;
   localparam logic [CFG_W-1:0]  LONG_PRESS_RST   = 16'd2000;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE     = 2'd0,
      CSR_DOUBLE_CLICK = 2'd1,
      CSR_LONG_PRESS   = 2'd2
   } csr_index_type;

   // Timing thresholds as seen by the event logic
   typedef struct packed {
      logic [CFG_W-1:0] debounce_ms;
      logic [CFG_W-1:0] double_click_ms;
      logic [CFG_W-1:0] long_press_ms;
   } bcq_cfg_type;

   // One poll's event flags
   typedef struct packed {
      logic single_click;
      logic double_click;
      logic long_press;
      logic turn_up;
      logic turn_down;
   } bcq_flags_type;

endpackage

// File: rtl/bcq_if.sv
// Poll request channel
interface bcq_req_if;
   import bcq_pkg::*;
   logic              valid;
   logic              ready;
   logic [PINS_W-1:0] pins;
   logic [TIME_W-1:0] now_ms;

   modport source (output valid, output pins, output now_ms, input ready);
   modport sink   (input valid, input pins, input now_ms, output ready);
endinterface

// Event flag response channel
interface bcq_rsp_if;
   logic valid;
   logic ready;
   logic single_click;
   logic double_click;
   logic long_press;
   logic turn_up;
   logic turn_down;

   modport source (output valid, output single_click, output double_click,
                   output long_press, output turn_up, output turn_down, input ready);
   modport sink   (input valid, input single_click, input double_click,
                   input long_press, input turn_up, input turn_down, output ready);
endinterface

// Configuration write channel
interface bcq_csr_if;
   import bcq_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/bcq_csr.sv
module bcq_csr (
   input  logic                       clock,
   input  logic                       reset,
   bcq_csr_if.sink                    csr_chan,
   output bcq_pkg::bcq_cfg_type       cfg
);
   import bcq_pkg::*;

   bcq_cfg_type cfg_ff;
   bcq_cfg_type cfg_in;

   // Writes are always taken; unknown indexes are dropped
   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_DEBOUNCE:     cfg_in.debounce_ms     = csr_chan.data;
            CSR_DOUBLE_CLICK: cfg_in.double_click_ms = csr_chan.data;
            CSR_LONG_PRESS:   cfg_in.long_press_ms   = csr_chan.data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms     <= DEBOUNCE_RST;
         cfg_ff.double_click_ms <= DOUBLE_CLICK_RST;
         cfg_ff.long_press_ms   <= LONG_PRESS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/bcq_eval.sv
module bcq_eval (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [bcq_pkg::PINS_W-1:0]   pins,
   input  logic [bcq_pkg::TIME_W-1:0]   now_ms,
   input  bcq_pkg::bcq_cfg_type         cfg,
   output bcq_pkg::bcq_flags_type       flags
);
   import bcq_pkg::*;

   logic [PINS_W-1:0] previous_pins_ff;
   logic [PINS_W-1:0] previous_pins_in;
   logic [TIME_W-1:0] event_stamp_ff;
   logic [TIME_W-1:0] event_stamp_in;

   logic [PINS_W-1:0] changed;
   logic [TIME_W-1:0] debounce_at;
   logic [TIME_W-1:0] double_until;
   logic [TIME_W-1:0] long_at;
   logic [TIME_W-1:0] enc_after;
   logic              button_up;
   logic              button_edge;
   logic              edge_counted;
   logic              press_restamp;
   logic              enc_fall;
   logic              enc_late;

   // Thresholds, all wrapping at 2^32
   assign debounce_at  = event_stamp_ff + TIME_W'(cfg.debounce_ms);
   assign double_until = event_stamp_ff + TIME_W'(cfg.double_click_ms);
   assign long_at      = event_stamp_ff + TIME_W'(cfg.long_press_ms);
   assign enc_after    = event_stamp_ff + TIME_W'(1);

   assign changed     = previous_pins_ff ^ pins;
   assign button_up   = pins[PIN_BUTTON];
   assign button_edge = changed[PIN_BUTTON];

   // Button events
   assign edge_counted  = button_edge && (now_ms >= debounce_at);
   assign press_restamp = edge_counted && !button_up && !(now_ms < double_until);

   // Encoder: falling A, tested against the stamp after any press restamp.
   // When restamped to now, now > now + 1 only where the sum wraps.
   assign enc_fall = changed[PIN_ENC_A] && !pins[PIN_ENC_A];
   assign enc_late = press_restamp ? (now_ms == '1) : (now_ms > enc_after);

   always_comb begin
      flags.single_click = edge_counted && button_up;
      flags.double_click = edge_counted && !button_up && (now_ms < double_until);
      flags.long_press   = !button_edge && !button_up && (now_ms >= long_at);
      flags.turn_up      = enc_fall && enc_late && !pins[PIN_ENC_B];
      flags.turn_down    = enc_fall && enc_late && pins[PIN_ENC_B];
   end

   // State update for the poll being retired
   always_comb begin
      previous_pins_in = previous_pins_ff;
      event_stamp_in   = event_stamp_ff;
      if (advance) begin
         previous_pins_in = pins;
         if (press_restamp || (enc_fall && enc_late)) begin
            event_stamp_in = now_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_pins_ff <= PINS_IDLE;
         event_stamp_ff   <= '0;
      end else begin
         previous_pins_ff <= previous_pins_in;
         event_stamp_ff   <= event_stamp_in;
      end
   end

endmodule

// File: rtl/button_click_encoder_qualifier.sv
// Button click and rotary encoder qualifier. Each request is one poll of the
// three pins (encoder A, encoder B, active-low button) with the current
// millisecond tick, and yields exactly one response of five event flags, in
// request order. A poll is captured in an input register, evaluated against
// the previous pin sample and the shared event stamp, and its flags land in
// an output register: one poll per clock is sustained while the response
// side is not stalled. The input register can hold one further request while
// a response waits. Thresholds are written through the csr channel (0
// debounce, 1 double click window, 2 long press time, in ms); the user must
// write them only while no poll is in flight, which the block does not
// enforce. Other indexes are ignored.
module button_click_encoder_qualifier (
   input  logic       clock,
   input  logic       reset,
   bcq_req_if.sink    req_chan,
   bcq_rsp_if.source  rsp_chan,
   bcq_csr_if.sink    csr_chan
);
   import bcq_pkg::*;

   logic              in_valid_ff;
   logic              in_valid_in;
   logic [PINS_W-1:0] in_pins_ff;
   logic [TIME_W-1:0] in_now_ff;
   logic              out_valid_ff;
   logic              out_valid_in;
   bcq_flags_type     out_flags_ff;
   bcq_flags_type     flags;
   bcq_cfg_type       cfg;
   logic              out_free;
   logic              advance;
   logic              req_take;

   // Configuration registers
   bcq_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // Pipeline control
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_pins_ff <= req_chan.pins;
         in_now_ff  <= req_chan.now_ms;
      end
   end

   // Event evaluation and state
   bcq_eval u_eval (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .pins    (in_pins_ff),
      .now_ms  (in_now_ff),
      .cfg     (cfg),
      .flags   (flags)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_flags_ff <= flags;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.single_click = out_flags_ff.single_click;
   assign rsp_chan.double_click = out_flags_ff.double_click;
   assign rsp_chan.long_press   = out_flags_ff.long_press;
   assign rsp_chan.turn_up      = out_flags_ff.turn_up;
   assign rsp_chan.turn_down    = out_flags_ff.turn_down;

   // A captured poll is never dropped while the output is blocked
   a_hold_poll: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff)
      else $error("pending poll lost while response stalled");

   // An empty input register always takes a request
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_chan.ready)
      else $error("input register empty but request refused");

   // Button events exclude each other
   a_button_onehot: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> $onehot0({out_flags_ff.single_click, out_flags_ff.double_click,
                                 out_flags_ff.long_press}))
      else $error("more than one button event in a response");

   // Encoder direction is unique
   a_turn_unique: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_flags_ff.turn_up && out_flags_ff.turn_down))
      else $error("turn up and turn down in the same response");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import bcq_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;  // unmapped index, ignored
   localparam int SETTLE_CYCLES   = 4;
   localparam int RSP_HOLD_CYCLES = 80;
   localparam int BLOCK_POLLS     = 275;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bcq_req_if req_if ();
   bcq_rsp_if rsp_if ();
   bcq_csr_if csr_if ();

   button_click_encoder_qualifier u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #6 clock = ~clock;

   // Shadow of the block's state and thresholds
   logic [PINS_W-1:0] last_pins = PINS_IDLE;
   logic [TIME_W-1:0] evt_stamp = '0;
   logic [TIME_W-1:0] last_now  = '0;
   bcq_cfg_type       thr       = '{DEBOUNCE_RST, DOUBLE_CLICK_RST, LONG_PRESS_RST};

   bcq_flags_type flags_due[$];
   int flag_errors  = 0;
   int polls_sent   = 0;
   int req_idle_pct = 8;
   int rsp_idle_pct = 84;
   int hold_req     = 0;
   int hold_ack     = 0;
   int hold_left    = 0;

   // Event flags for one poll; advances the shadow state
   function automatic bcq_flags_type qualify_poll(input logic [PINS_W-1:0] pins,
                                                 input logic [TIME_W-1:0] now);
      logic [PINS_W-1:0] moved;
      logic [TIME_W-1:0] lim;
      bcq_flags_type     f;
      moved = last_pins ^ pins;
      f = '0;
      if (moved[PIN_BUTTON]) begin
         lim = evt_stamp + thr.debounce_ms;
         if (now >= lim) begin
            lim = evt_stamp + thr.double_click_ms;
            if (pins[PIN_BUTTON])
               f.single_click = 1'b1;
            else if (now < lim)
               f.double_click = 1'b1;
            else
               evt_stamp = now;
         end
      end else begin
         lim = evt_stamp + thr.long_press_ms;
         if (!pins[PIN_BUTTON] && now >= lim)
            f.long_press = 1'b1;
      end
      // encoder sees the stamp as left by a press in this same poll
      if (moved[PIN_ENC_A] && !pins[PIN_ENC_A]) begin
         lim = evt_stamp + 32'd1;
         if (now > lim) begin
            if (pins[PIN_ENC_B])
               f.turn_down = 1'b1;
            else
               f.turn_up = 1'b1;
            evt_stamp = now;
         end
      end
      last_pins = pins;
      return f;
   endfunction

   // Tick value near one of the thresholds, or anywhere
   function automatic logic [TIME_W-1:0] pick_time();
      int jit;
      jit = $urandom_range(2) - 1;
      case ($urandom_range(9))
         0:       return evt_stamp + thr.debounce_ms + jit;
         1:       return evt_stamp + thr.double_click_ms + jit;
         2:       return evt_stamp + thr.long_press_ms + jit;
         3:       return evt_stamp + 1 + jit;
         4:       return evt_stamp + $urandom_range(3);
         5, 6:    return evt_stamp + $urandom_range(int'(thr.long_press_ms) + 100);
         7:       return $urandom;
         default: return last_now + $urandom_range(50);
      endcase
   endfunction

   // Send one poll request; valid stays high for a following request
   task automatic send_poll(input logic [PINS_W-1:0] pins, input logic [TIME_W-1:0] now);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.pins   <= pins;
      req_if.now_ms <= now;
      do @(posedge clock); while (!req_if.ready);
      flags_due.push_back(qualify_poll(pins, now));
      last_now = now;
      polls_sent++;
   endtask

   // Stop sending and wait for every outstanding response
   task automatic drain_responses(input int settle);
      req_if.valid <= 1'b0;
      while (flags_due.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         CSR_DEBOUNCE:     thr.debounce_ms     = val;
         CSR_DOUBLE_CLICK: thr.double_click_ms = val;
         CSR_LONG_PRESS:   thr.long_press_ms   = val;
         default: ;
      endcase
   endtask

   // Load all thresholds once the block is idle
   task automatic program_thresholds(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] dbl,
                                     input logic [CFG_W-1:0] lng, input bit poke_spare);
      drain_responses(SETTLE_CYCLES);
      write_reg(CSR_DEBOUNCE, deb);
      write_reg(CSR_DOUBLE_CLICK, dbl);
      write_reg(CSR_LONG_PRESS, lng);
      if (poke_spare)
         write_reg(CSR_SPARE, CFG_W'($urandom));
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // One user gesture: click, double click, encoder detent, or line noise
   task automatic run_gesture();
      logic [PINS_W-1:0] p;
      logic [1:0]        steps [4];
      int                kind;
      int                n;
      p = last_pins;
      kind = $urandom_range(99);
      if (kind < 30) begin
         p[PIN_BUTTON] = 1'b0;
         send_poll(p, pick_time());
         n = $urandom_range(3);
         repeat (n) send_poll(p, pick_time());
         p[PIN_BUTTON] = 1'b1;
         send_poll(p, pick_time());
      end else if (kind < 45) begin
         repeat (2) begin
            p[PIN_BUTTON] = 1'b0;
            send_poll(p, pick_time());
            p[PIN_BUTTON] = 1'b1;
            send_poll(p, pick_time());
         end
      end else if (kind < 82) begin
         // full quadrature cycle as {B, A}, starting from both high
         if ($urandom_range(1))
            steps = '{2'b01, 2'b00, 2'b10, 2'b11};
         else
            steps = '{2'b10, 2'b00, 2'b01, 2'b11};
         if (p[1:0] != 2'b11) begin
            p[1:0] = 2'b11;
            send_poll(p, pick_time());
         end
         for (int i = 0; i < 4; i++) begin
            p[1:0] = steps[i];
            send_poll(p, pick_time());
         end
      end else begin
         n = $urandom_range(1, 4);
         repeat (n) send_poll(PINS_W'($urandom_range(7)), $urandom);
      end
   endtask

   // Debounce, double click window, restamp and long press under reset thresholds
   task automatic test_button_events();
      send_poll(3'd7, 32'd100);
      send_poll(3'd3, 32'd5);       // press too early
      send_poll(3'd7, 32'd8);       // release too early
      send_poll(3'd3, 32'd200);     // double click
      send_poll(3'd7, 32'd300);     // single click
      send_poll(3'd3, 32'd600);     // restamp
      send_poll(3'd3, 32'd2599);
      send_poll(3'd3, 32'd2600);    // long press
      send_poll(3'd7, 32'd2700);
   endtask

   // Turn direction, rising A, B alone, too soon after stamp, press in same poll
   task automatic test_encoder_turns();
      send_poll(3'd6, 32'd3000);    // A falls, B high
      send_poll(3'd7, 32'd3001);
      send_poll(3'd6, 32'd3001);    // within one tick of stamp
      send_poll(3'd7, 32'd3005);
      send_poll(3'd5, 32'd3010);    // B alone
      send_poll(3'd4, 32'd3020);    // A falls, B low
      send_poll(3'd5, 32'd3030);
      send_poll(3'd0, 32'd4000);    // press restamps, then encoder too soon
   endtask

   // Thresholds that wrap past 2^32
   task automatic test_time_wrap();
      send_poll(3'd5, 32'hFFFF_FFF0);
      send_poll(3'd4, 32'hFFFF_FFFA);
      send_poll(3'd0, 32'h0000_0005);
      send_poll(3'd7, 32'hFFFF_FFFF);
      send_poll(3'd6, 32'h0000_0000);
   endtask

   // Receiver holds off while requests pile up, then sender waits for all responses
   task automatic test_backpressure();
      req_idle_pct = 0;
      hold_req++;
      repeat (40) run_gesture();
      drain_responses(0);
      repeat (10) run_gesture();
      req_idle_pct = 8;
   endtask

   // Random gestures over several threshold settings and idle patterns
   task automatic test_random_traffic();
      int stop_at;
      for (int blk = 0; blk < 6; blk++) begin
         case (blk)
            0: program_thresholds(DEBOUNCE_RST, DOUBLE_CLICK_RST, LONG_PRESS_RST, 1'b0);
            1: program_thresholds(16'd3, 16'd40, 16'd120, 1'b0);
            2: program_thresholds(16'd0, 16'd0, 16'd0, 1'b0);
            3: program_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
            4: program_thresholds(CFG_W'($urandom_range(60)), CFG_W'($urandom_range(900)),
                                  CFG_W'($urandom_range(3000)), 1'b1);
            default: program_thresholds(CFG_W'($urandom_range(200, 900)),
                                        CFG_W'($urandom_range(200)),
                                        CFG_W'($urandom_range(3000)), 1'b0);
         endcase
         case (blk / 2)
            0: begin req_idle_pct = 8;  rsp_idle_pct = 84; end
            1: begin req_idle_pct = 84; rsp_idle_pct = 8;  end
            default: begin req_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         stop_at = polls_sent + BLOCK_POLLS;
         while (polls_sent < stop_at)
            run_gesture();
      end
   endtask

   // Receiver ready, with a long hold-off on request
   always @(posedge clock) begin
      if (hold_req != hold_ack) begin
         hold_ack = hold_req;
         hold_left = RSP_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   function automatic void check_flag(input string name, input logic want, input logic got);
      if (got !== want) begin
         $error("%s: expected %0b, actual %0b", name, want, got);
         flag_errors++;
      end
   endfunction

   // Compare each response with the oldest pending prediction
   always @(posedge clock) begin
      bcq_flags_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (flags_due.size() == 0) begin
            $error("response with no poll pending");
            flag_errors++;
         end else begin
            want = flags_due.pop_front();
            check_flag("single_click", want.single_click, rsp_if.single_click);
            check_flag("double_click", want.double_click, rsp_if.double_click);
            check_flag("long_press", want.long_press, rsp_if.long_press);
            check_flag("turn_up", want.turn_up, rsp_if.turn_up);
            check_flag("turn_down", want.turn_down, rsp_if.turn_down);
         end
      end
   end

   initial begin
      req_if.valid  = 1'b0;
      req_if.pins   = PINS_IDLE;
      req_if.now_ms = '0;
      csr_if.valid  = 1'b0;
      csr_if.index  = CSR_DEBOUNCE;
      csr_if.data   = '0;
      rsp_if.ready  = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_button_events();
      test_encoder_turns();
      test_time_wrap();
      test_backpressure();
      test_random_traffic();

      drain_responses(8);
      if (flag_errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Watchdog
   initial begin
      #(10_000_000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
